// ----- sv/pairwise_coincidence_histogram_unit_defines.svh -----
// assertion macros used by pcoh_back
`ifndef PAIRWISE_COINCIDENCE_HISTOGRAM_UNIT_DEFINES_SVH
`define PAIRWISE_COINCIDENCE_HISTOGRAM_UNIT_DEFINES_SVH

// same-cycle implication
`define PCOH_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("pcoh: check failed");

// next-cycle implication
`define PCOH_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("pcoh: check failed");

`endif

// ----- sv/pcoh_pkg.sv -----
`default_nettype none

package pcoh_pkg;

    localparam int MAX_PARAMS       = 8;
    localparam int PARAM_BITS       = 16;
    localparam int AXIS_BITS        = 8;
    localparam int COUNT_BITS       = 16;
    localparam int SHIFT_BITS       = 5;
    localparam int CFG_BITS         = 4;
    localparam int CFG_DATA_BITS    = MAX_PARAMS * SHIFT_BITS;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int IDX_BITS         = $clog2(MAX_PARAMS);
    localparam int POS_BITS         = $clog2(MAX_PARAMS + 1);
    localparam int HIST_ADDR_BITS   = 2 * AXIS_BITS;
    localparam int FUNC_BITS        = 2;
    localparam int CMD_DEPTH_DEF    = 2;
    localparam int RES_DEPTH_DEF    = 2;

    localparam logic [FUNC_BITS-1:0] FUNC_EVENT = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_WRITE = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_X_BITS      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_BITS      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PARAM_COUNT = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT_TABLE = 2'd3;

    typedef struct packed {
        logic [FUNC_BITS-1:0]  func;
        logic [PARAM_BITS-1:0] param_value;
        logic                  param_valid;
        logic                  last_param;
        logic [AXIS_BITS-1:0]  bin_x;
        logic [AXIS_BITS-1:0]  bin_y;
        logic [COUNT_BITS-1:0] write_value;
    } item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] read_value;
        logic                  range_error;
    } result_t;

    // work handed from the front to the back
    typedef struct packed {
        logic [FUNC_BITS-1:0]                   func;
        logic [MAX_PARAMS-1:0][PARAM_BITS-1:0]  values;
        logic [MAX_PARAMS-1:0]                  mask;
        logic [AXIS_BITS-1:0]                   bin_x;
        logic [AXIS_BITS-1:0]                   bin_y;
        logic [COUNT_BITS-1:0]                  write_value;
    } cmd_t;

    // clamped configuration
    typedef struct packed {
        logic [CFG_BITS-1:0]                    x_bits;
        logic [CFG_BITS-1:0]                    y_bits;
        logic [CFG_BITS-1:0]                    param_count;
        logic [MAX_PARAMS-1:0][SHIFT_BITS-1:0]  shift;
    } cfg_t;

endpackage

`default_nettype wire

// ----- sv/pcoh_fifo.sv -----
`default_nettype none

module pcoh_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ----- sv/pcoh_cfg.sv -----
`default_nettype none

module pcoh_cfg (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [pcoh_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [pcoh_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output pcoh_pkg::cfg_t                             cfg
);

    import pcoh_pkg::*;

    logic [CFG_BITS-1:0]      x_bits_reg, y_bits_reg, param_count_reg;
    logic [CFG_DATA_BITS-1:0] shift_table_reg;

    function automatic logic [CFG_BITS-1:0] clamp(
        input logic [CFG_BITS-1:0] v,
        input logic [CFG_BITS-1:0] lo,
        input logic [CFG_BITS-1:0] hi
    );
        logic [CFG_BITS-1:0] r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_bits_reg      <= CFG_BITS'(AXIS_BITS);
            y_bits_reg      <= CFG_BITS'(AXIS_BITS);
            param_count_reg <= CFG_BITS'(2);
            shift_table_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_X_BITS:      x_bits_reg      <= cfg_data[CFG_BITS-1:0];
                REG_Y_BITS:      y_bits_reg      <= cfg_data[CFG_BITS-1:0];
                REG_PARAM_COUNT: param_count_reg <= cfg_data[CFG_BITS-1:0];
                REG_SHIFT_TABLE: shift_table_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cfg.x_bits      = clamp(x_bits_reg, CFG_BITS'(1), CFG_BITS'(AXIS_BITS));
        cfg.y_bits      = clamp(y_bits_reg, CFG_BITS'(1), CFG_BITS'(AXIS_BITS));
        cfg.param_count = clamp(param_count_reg, CFG_BITS'(2), CFG_BITS'(MAX_PARAMS));
        cfg.shift       = shift_table_reg;
    end

endmodule

`default_nettype wire

// ----- sv/pcoh_front.sv -----
`default_nettype none

module pcoh_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire pcoh_pkg::item_t item,
    input  wire logic            clearing,
    input  wire logic            cmd_full,
    output logic                 cmd_push,
    output pcoh_pkg::cmd_t       cmd_data
);

    import pcoh_pkg::*;

    logic [MAX_PARAMS-1:0][PARAM_BITS-1:0] values_reg, values_next;
    logic [MAX_PARAMS-1:0]                 mask_reg, mask_next, mask_upd;
    logic [POS_BITS-1:0]                   pos_reg, pos_next;
    logic                                  accept;

    assign full   = cmd_full || clearing;
    assign accept = push && !full;

    always_comb
    begin
        values_next = values_reg;
        mask_upd    = mask_reg;
        pos_next    = pos_reg;
        cmd_push    = 1'b0;
        if (accept)
        begin
            case (item.func) inside
                FUNC_EVENT:
                begin
                    // positions past the end are dropped, the last mark still counts
                    if (pos_reg < POS_BITS'(MAX_PARAMS))
                    begin
                        values_next[pos_reg[IDX_BITS-1:0]] = item.param_value;
                        if (item.param_valid)
                        begin
                            mask_upd[pos_reg[IDX_BITS-1:0]] = 1'b1;
                        end
                        pos_next = pos_reg + 1'b1;
                    end
                    if (item.last_param)
                    begin
                        cmd_push = 1'b1;
                        pos_next = '0;
                    end
                end
                FUNC_READ, FUNC_WRITE:
                begin
                    cmd_push = 1'b1;
                end
                default: ;
            endcase
        end
        mask_next = (cmd_push && item.func == FUNC_EVENT) ? '0 : mask_upd;

        cmd_data.func        = item.func;
        cmd_data.values      = values_next;
        cmd_data.mask        = mask_upd;
        cmd_data.bin_x       = item.bin_x;
        cmd_data.bin_y       = item.bin_y;
        cmd_data.write_value = item.write_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        values_reg <= values_next;
    end

endmodule

`default_nettype wire

// ----- sv/pcoh_back.sv -----
`default_nettype none
`include "pairwise_coincidence_histogram_unit_defines.svh"

module pcoh_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire pcoh_pkg::cfg_t  cfg,
    input  wire pcoh_pkg::cmd_t  cmd,
    input  wire logic            cmd_empty,
    output logic                 cmd_pop,
    input  wire logic            res_full,
    output logic                 res_push,
    output pcoh_pkg::result_t    res_data,
    output logic                 clearing
);

    import pcoh_pkg::*;

    localparam int SCALED_BITS = PARAM_BITS + (1 << (SHIFT_BITS - 1));
    localparam int STATE_BITS  = 3;

    localparam logic [STATE_BITS-1:0] ST_CLEAR  = 3'd0;
    localparam logic [STATE_BITS-1:0] ST_IDLE   = 3'd1;
    localparam logic [STATE_BITS-1:0] ST_OUTER  = 3'd2;
    localparam logic [STATE_BITS-1:0] ST_INNER  = 3'd3;
    localparam logic [STATE_BITS-1:0] ST_RDWAIT = 3'd4;

    // signed shift, positive goes right, left shifts kept exact
    function automatic logic [SCALED_BITS-1:0] scale_value(
        input logic [PARAM_BITS-1:0] v,
        input logic [SHIFT_BITS-1:0] s
    );
        logic [SCALED_BITS-1:0] ext;
        logic [SHIFT_BITS-1:0]  amt;
        ext = SCALED_BITS'(v);
        amt = -s;
        if (s[SHIFT_BITS-1])
        begin
            return ext << amt;
        end
        return ext >> s;
    endfunction

    function automatic logic [HIST_ADDR_BITS-1:0] bin_addr(
        input logic [AXIS_BITS-1:0] x,
        input logic [AXIS_BITS-1:0] y,
        input logic [CFG_BITS-1:0]  xb
    );
        return HIST_ADDR_BITS'(x) | (HIST_ADDR_BITS'(y) << xb);
    endfunction

    logic [COUNT_BITS-1:0] hist [1 << HIST_ADDR_BITS];

    logic [STATE_BITS-1:0]                 state_reg, state_next;
    logic [HIST_ADDR_BITS-1:0]             clr_cnt_reg, clr_cnt_next;
    logic [IDX_BITS-1:0]                   i_reg, i_next, j_reg, j_next, sel_idx;
    logic [AXIS_BITS-1:0]                  px_reg, px_next;
    logic [MAX_PARAMS-1:0][PARAM_BITS-1:0] ev_values_reg, ev_values_next;
    logic [MAX_PARAMS-1:0]                 ev_mask_reg, ev_mask_next;
    logic                                  rmw_valid_reg, rmw_valid_next;
    logic [HIST_ADDR_BITS-1:0]             rmw_addr_reg, rmw_addr_next;
    logic                                  last_valid_reg;
    logic [HIST_ADDR_BITS-1:0]             last_addr_reg;
    logic [COUNT_BITS-1:0]                 last_data_reg;
    logic [COUNT_BITS-1:0]                 rd_data_reg;

    logic [SCALED_BITS-1:0]    scaled;
    logic                      fits_x, fits_y;
    logic [HIST_ADDR_BITS-1:0] pair_addr, acc_addr;
    logic                      acc_err, acc_we;
    logic [CFG_BITS-1:0]       n_last;
    logic [COUNT_BITS-1:0]     inc_value;
    logic                      mem_re, mem_we;
    logic [HIST_ADDR_BITS-1:0] mem_raddr, mem_waddr;
    logic [COUNT_BITS-1:0]     mem_wdata;

    assign clearing = (state_reg == ST_CLEAR);
    assign n_last   = cfg.param_count - 1'b1;

    // one value read port: outer position while loading x, inner while pairing
    assign sel_idx  = (state_reg == ST_INNER) ? j_reg : i_reg;
    assign scaled   = scale_value(ev_values_reg[sel_idx], cfg.shift[sel_idx]);
    assign fits_x   = ((scaled >> cfg.x_bits) == '0);
    assign fits_y   = ((scaled >> cfg.y_bits) == '0);
    assign pair_addr = bin_addr(px_reg, scaled[AXIS_BITS-1:0], cfg.x_bits);

    assign acc_err  = ((cmd.bin_x >> cfg.x_bits) != '0) || ((cmd.bin_y >> cfg.y_bits) != '0);
    assign acc_addr = bin_addr(cmd.bin_x, cmd.bin_y, cfg.x_bits);

    // forward the counter written last edge, the memory read missed it
    assign inc_value = ((last_valid_reg && last_addr_reg == rmw_addr_reg) ?
                        last_data_reg : rd_data_reg) + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        px_next        = px_reg;
        ev_values_next = ev_values_reg;
        ev_mask_next   = ev_mask_reg;
        rmw_valid_next = 1'b0;
        rmw_addr_next  = rmw_addr_reg;
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        res_data       = '0;
        acc_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = acc_addr;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    if (cmd.func == FUNC_EVENT)
                    begin
                        cmd_pop        = 1'b1;
                        ev_values_next = cmd.values;
                        ev_mask_next   = cmd.mask;
                        i_next         = '0;
                        state_next     = ST_OUTER;
                    end
                    else if (!rmw_valid_reg && !res_full)
                    begin
                        cmd_pop = 1'b1;
                        if (acc_err)
                        begin
                            res_push             = 1'b1;
                            res_data.range_error = 1'b1;
                        end
                        else if (cmd.func == FUNC_WRITE)
                        begin
                            acc_we   = 1'b1;
                            res_push = 1'b1;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_RDWAIT;
                        end
                    end
                end
            end
            ST_OUTER:
            begin
                if (CFG_BITS'(i_reg) >= n_last)
                begin
                    state_next = ST_IDLE;
                end
                else if (ev_mask_reg[i_reg] && fits_x)
                begin
                    px_next    = scaled[AXIS_BITS-1:0];
                    j_next     = i_reg + 1'b1;
                    state_next = ST_INNER;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_INNER:
            begin
                if (ev_mask_reg[j_reg] && fits_y)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = pair_addr;
                    rmw_valid_next = 1'b1;
                    rmw_addr_next  = pair_addr;
                end
                if (CFG_BITS'(j_reg) == n_last)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_OUTER;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_RDWAIT:
            begin
                res_push            = 1'b1;
                res_data.read_value = rd_data_reg;
                state_next          = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = rmw_addr_reg;
        mem_wdata = inc_value;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (rmw_valid_reg)
        begin
            mem_we = 1'b1;
        end
        else if (acc_we)
        begin
            mem_we    = 1'b1;
            mem_waddr = acc_addr;
            mem_wdata = cmd.write_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            ev_mask_reg    <= '0;
            rmw_valid_reg  <= 1'b0;
            last_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            ev_mask_reg    <= ev_mask_next;
            rmw_valid_reg  <= rmw_valid_next;
            last_valid_reg <= rmw_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg        <= px_next;
        ev_values_reg <= ev_values_next;
        rmw_addr_reg  <= rmw_addr_next;
        last_addr_reg <= rmw_addr_reg;
        last_data_reg <= inc_value;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= hist[mem_raddr];
        end
    end

    `PCOH_ASSERT_IMPL(a_rdwait_room, clk, rst_n, state_reg == ST_RDWAIT, !res_full)
    `PCOH_ASSERT_IMPL(a_clear_quiet, clk, rst_n, state_reg == ST_CLEAR, !rmw_valid_reg && !cmd_pop)
    `PCOH_ASSERT_NEXT(a_clear_full_sweep, clk, rst_n, state_reg == ST_CLEAR && clr_cnt_reg != '1, state_reg == ST_CLEAR)
    `PCOH_ASSERT_IMPL(a_pair_order, clk, rst_n, state_reg == ST_INNER, j_reg > i_reg)

endmodule

`default_nettype wire

// ----- sv/pairwise_coincidence_histogram_unit.sv -----
// with the back end idle a read result passes the command queue, histogram read register and
//   result queue to the result ports, a write or range error result the two queues alone
// throughput: event items are taken one a cycle while full is low; closing an event keeps the
//   pair sequencer busy over its position pairs, one histogram increment a cycle
// reset: full stays high after reset while the histogram is swept to zero,
//   one counter a cycle; configuration writes are taken during the sweep
`default_nettype none

module pairwise_coincidence_histogram_unit #(
    parameter int CMD_DEPTH = pcoh_pkg::CMD_DEPTH_DEF,
    parameter int RES_DEPTH = pcoh_pkg::RES_DEPTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // input side
    input  wire logic                                  push,
    output logic                                       full,
    input  wire pcoh_pkg::item_t                       item,
    // result side
    output logic                                       empty,
    input  wire logic                                  pop,
    output pcoh_pkg::result_t                          result,
    // configuration writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [pcoh_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [pcoh_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    import pcoh_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd_in, cmd_out;
    result_t res_in;
    logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic    res_push, res_full;
    logic    clearing;

    // register file, clamps axis bits and parameter count
    pcoh_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // front: gathers event positions, emits one command per closed event or access
    pcoh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .clearing (clearing),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd_data (cmd_in)
    );

    // command queue decouples gathering from pair processing
    pcoh_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty)
    );

    // back: pair sequencer, histogram memory with increment pipeline, bin accesses
    pcoh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_in),
        .clearing  (clearing)
    );

    // result queue, head item drives the result ports
    pcoh_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire
